[rtl/core/fpd_pkg.sv]
// Shared constants and types for the fixed-point divider.
`timescale 1ns / 1ps
package fpd_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int EXP_W     = 8;
   localparam int CNT_W     = $clog2(DATA_W + 1);

   localparam logic [DATA_W-1:0] QUO_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] QUO_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic             done;
      logic [EXP_W-1:0] exponent;
   } norm_stat_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] mag_quo;
   } div_stat_type;

endpackage

[rtl/core/fpd_req_if.sv]
// Request channel interface: dividend and divisor with valid/ready.
`timescale 1ns / 1ps
interface fpd_req_if import fpd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] dividend;
   logic signed [DATA_W-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

[rtl/core/fpd_rsp_if.sv]
// Response channel interface: quotient with valid/ready.
`timescale 1ns / 1ps
interface fpd_rsp_if import fpd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] quotient;

   modport source (output valid, output quotient, input ready);
   modport sink   (input valid, input quotient, output ready);
endinterface

[rtl/core/fpd_norm.sv]
// Normalizer: shifts the dividend left and strips divisor trailing zeros, one bit a cycle.
`timescale 1ns / 1ps
module fpd_norm import fpd_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] x_norm,
   output logic [DATA_W-1:0] y_norm,
   output norm_stat_type     stat
);

   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic              x_shift;
   logic              y_shift;

   assign x_shift = (x_ff[DATA_W-1] == x_ff[DATA_W-2]);
   assign y_shift = ~y_ff[0];

   always_comb begin
      if (load) begin
         x_in   = dividend;
         y_in   = divisor;
         exp_in = EXP_W'(FRAC_BITS);
      end else begin
         x_in   = x_shift ? {x_ff[DATA_W-2:0], 1'b0} : x_ff;
         y_in   = y_shift ? {y_ff[DATA_W-1], y_ff[DATA_W-1:1]} : y_ff;
         exp_in = exp_ff - EXP_W'(x_shift) - EXP_W'(y_shift);
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      exp_ff <= exp_in;
   end

   assign x_norm        = x_ff;
   assign y_norm        = y_ff;
   assign stat.done     = ~x_shift & ~y_shift;
   assign stat.exponent = exp_ff;

endmodule

[rtl/core/fpd_div.sv]
// Restoring divider on magnitudes: one quotient bit per cycle.
`timescale 1ns / 1ps
module fpd_div import fpd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [DATA_W-1:0] ma,
   input  logic [DATA_W-1:0] mb,
   output div_stat_type      stat
);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] mb_ff, mb_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, mb_ff};
   assign fits  = ~diff[DATA_W];

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      mb_in  = mb_ff;
      if (load) begin
         cnt_in = CNT_W'(DATA_W);
         rem_in = '0;
         quo_in = ma;
         mb_in  = mb;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mb_ff  <= mb_in;
   end

   assign stat.done    = (cnt_ff == '0);
   assign stat.mag_quo = quo_ff;

endmodule

[rtl/core/fixed_point_divider_top.sv]
// Top level of the signed 16.16 fixed-point divider.
//
// Usage:
//   req carries a signed dividend and divisor; rsp returns the signed
//   quotient. Transfers happen on clock edges where valid and ready are high.
//   One item is in work at a time; req.ready is high only when idle.
//   After the req transfer the normalizer shifts the dividend left until its
//   top two bits differ and strips the divisor's trailing zeros (each 0..31
//   bits, in parallel), then the restoring divide loop runs and the scale
//   step writes the output register. A zero divisor or zero dividend goes
//   straight to the scale step. req.ready rises together with rsp.valid,
//   so the next request can transfer once the previous result is written.
//   The quotient waits in an output register; while rsp is stalled the
//   block may take the next request and holds its finished result in the
//   scale step until the output register frees.
//   Divide by zero saturates: most negative for a negative dividend,
//   most positive otherwise.
//   Reset is synchronous, active high: it idles the sequencer and drops
//   rsp.valid.
`timescale 1ns / 1ps
module fixed_point_divider_top import fpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fpd_req_if.sink   req,
   fpd_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_NORM  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_SCALE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] quotient_ff, quotient_in;
   logic              special_ff, special_in;
   logic [DATA_W-1:0] special_val_ff, special_val_in;
   logic              neg_ff, neg_in;

   logic              req_xfer;
   logic              div_load;
   logic [DATA_W-1:0] x_norm;
   logic [DATA_W-1:0] y_norm;
   logic [DATA_W-1:0] ma;
   logic [DATA_W-1:0] mb;
   logic [DATA_W-1:0] q_signed;
   logic [DATA_W-1:0] scaled;
   logic [EXP_W-1:0]  neg_exp;
   logic              out_free;
   norm_stat_type     norm_stat;
   div_stat_type      div_stat;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid & req.ready;
   assign out_free  = ~rsp_valid_ff | rsp.ready;

   fpd_norm u_norm (
      .clock    (clock),
      .load     (req_xfer),
      .dividend (req.dividend),
      .divisor  (req.divisor),
      .x_norm   (x_norm),
      .y_norm   (y_norm),
      .stat     (norm_stat)
   );

   assign ma = x_norm[DATA_W-1] ? (~x_norm + 1'b1) : x_norm;
   assign mb = y_norm[DATA_W-1] ? (~y_norm + 1'b1) : y_norm;

   fpd_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .ma    (ma),
      .mb    (mb),
      .stat  (div_stat)
   );

   // scale by the leftover exponent: wrapping left shift or arithmetic right shift
   assign neg_exp = ~norm_stat.exponent + 1'b1;

   always_comb begin
      q_signed = neg_ff ? (~div_stat.mag_quo + 1'b1) : div_stat.mag_quo;
      if (!norm_stat.exponent[EXP_W-1]) begin
         if (norm_stat.exponent >= EXP_W'(DATA_W)) begin
            scaled = '0;
         end else begin
            scaled = q_signed << norm_stat.exponent[CNT_W-2:0];
         end
      end else begin
         if (neg_exp >= EXP_W'(DATA_W)) begin
            scaled = {DATA_W{q_signed[DATA_W-1]}};
         end else begin
            scaled = DATA_W'($signed(q_signed) >>> neg_exp[CNT_W-2:0]);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      quotient_in    = quotient_ff;
      special_in     = special_ff;
      special_val_in = special_val_ff;
      neg_in         = neg_ff;
      div_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               neg_in = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
               if (req.divisor == '0) begin
                  special_in     = 1'b1;
                  special_val_in = req.dividend[DATA_W-1] ? QUO_MIN : QUO_MAX;
                  state_in       = ST_SCALE;
               end else if (req.dividend == '0) begin
                  special_in     = 1'b1;
                  special_val_in = '0;
                  state_in       = ST_SCALE;
               end else begin
                  special_in = 1'b0;
                  state_in   = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (norm_stat.done) begin
               div_load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (out_free) begin
               quotient_in  = special_ff ? special_val_ff : scaled;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         special_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         special_ff   <= special_in;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff    <= quotient_in;
      special_val_ff <= special_val_in;
      neg_ff         <= neg_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.quotient = quotient_ff;

endmodule

[rtl/core/fpd_checker.sv]
// Port-level checker for the fixed-point divider, bound to the top level.
`timescale 1ns / 1ps
module fpd_checker import fpd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [DATA_W-1:0] req_dividend,
   input logic [DATA_W-1:0] req_divisor,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_quotient
);

   // a stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient))
      else $error("response dropped or changed while stalled");

   // one item at a time: busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // a new response appears only as the block goes idle
   a_rsp_rise_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response raised while still busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the block");

   // a response cannot appear in the cycle right after a nonzero-divide request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_divisor != '0) && (req_dividend != '0) && !rsp_valid
      |=> !rsp_valid)
      else $error("response appeared too early");

endmodule

bind fixed_point_divider_top fpd_checker u_fpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_dividend (req.dividend),
   .req_divisor  (req.divisor),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_quotient (rsp.quotient)
);
